FILE: src/acfp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII CAN frame parser package
// Shared constants, types and the hex digit decoder of the parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned NIBBLE_W       = 4;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned ACC_ID_W       = 32;
  localparam int unsigned ID_W           = 29;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned PAYLOAD_W      = 64;
  localparam int unsigned STD_ID_DIGITS  = 3;
  localparam int unsigned EXT_ID_DIGITS  = 8;

  localparam logic [ACC_ID_W-1:0] STD_ID_MAX = 32'h0000_07ff;
  localparam logic [ACC_ID_W-1:0] EXT_ID_MAX = 32'h1fff_ffff;

  localparam logic [CHAR_W-1:0] CHAR_STD_DATA = 8'h74;  // 't'
  localparam logic [CHAR_W-1:0] CHAR_EXT_DATA = 8'h54;  // 'T'
  localparam logic [CHAR_W-1:0] CHAR_STD_RTR  = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CHAR_EXT_RTR  = 8'h52;  // 'R'
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F  = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F  = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] HEX_TEN       = 8'd10;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CMD = 2'd1,
    STATUS_BAD_ID  = 2'd2,
    STATUS_BAD_LEN = 2'd3
  } status_e;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              line_start;
  } char_t;

  typedef struct packed {
    status_e              status;
    logic                 extended;
    logic                 remote;
    logic [ID_W-1:0]      identifier;
    logic [LEN_W-1:0]     byte_count;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  // Characters outside 0-9, A-F and a-f decode as zero.
  function automatic logic [NIBBLE_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      diff = c - CHAR_UPPER_A + HEX_TEN;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      diff = c - CHAR_LOWER_A + HEX_TEN;
    end
    return diff[NIBBLE_W-1:0];
  endfunction

endpackage

FILE: src/acfp_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one command character per transaction.
// ----------------------------------------------------------------------------
interface acfp_char_if;
  logic                           valid;
  logic                           ready;
  logic [acfp_pkg::CHAR_W-1:0]    character;
  logic                           line_start;

  modport source (output valid, character, line_start, input ready);
  modport sink   (input valid, character, line_start, output ready);
endinterface

FILE: src/acfp_frame_if.sv
// ----------------------------------------------------------------------------
// Frame channel
// Valid/ready channel that carries one parsed frame per transaction.
// ----------------------------------------------------------------------------
interface acfp_frame_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             extended;
  logic                             remote;
  logic [acfp_pkg::ID_W-1:0]        identifier;
  logic [acfp_pkg::LEN_W-1:0]       byte_count;
  logic [acfp_pkg::PAYLOAD_W-1:0]   payload;

  modport source (output valid, status, extended, remote, identifier, byte_count, payload,
                  input ready);
  modport sink   (input valid, status, extended, remote, identifier, byte_count, payload,
                  output ready);
endinterface

FILE: src/acfp_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one character per transaction and holds it until the parser
// step can take it.
// ----------------------------------------------------------------------------
module acfp_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [acfp_pkg::CHAR_W-1:0]   character_i,
  input  logic                          line_start_i,
  input  logic                          advance_i,
  output logic                          valid_o,
  output acfp_pkg::char_t               char_o
);

  logic            valid_q, valid_d;
  acfp_pkg::char_t char_q;

  // The register frees up in the same cycle that its character moves on.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      char_q.character  <= character_i;
      char_q.line_start <= line_start_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

FILE: src/acfp_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Holds the command state and applies one character per step, giving the
// frame when the command completes or fails.
// ----------------------------------------------------------------------------
module acfp_core #(
  parameter int unsigned MaxDataBytes = acfp_pkg::MAX_DATA_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  acfp_pkg::char_t   char_i,
  output logic              res_valid_o,
  output acfp_pkg::frame_t  res_o
);

  localparam int unsigned DataW   = 8 * MaxDataBytes;
  localparam int unsigned Nibbles = 2 * MaxDataBytes;
  localparam int unsigned PosMax  = acfp_pkg::EXT_ID_DIGITS + 2 * MaxDataBytes;

  logic [acfp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic                          active_q, active_d;
  logic                          ext_q, ext_d;
  logic                          rem_q, rem_d;
  logic [acfp_pkg::ACC_ID_W-1:0] id_q, id_d;
  logic [acfp_pkg::LEN_W-1:0]    len_q, len_d;
  logic [DataW-1:0]              pay_q, pay_d;

  logic [acfp_pkg::NIBBLE_W-1:0] digit;
  logic [acfp_pkg::POS_W-1:0]    id_digits;
  logic [acfp_pkg::POS_W-1:0]    pos_inc;
  logic [acfp_pkg::POS_W-1:0]    data_idx;
  logic [acfp_pkg::POS_W-1:0]    nib_idx;
  logic [acfp_pkg::ACC_ID_W-1:0] id_shift;
  logic [acfp_pkg::ACC_ID_W-1:0] id_limit;
  logic                          letter_ok;
  logic                          emit;
  acfp_pkg::status_e             status;

  assign digit     = acfp_pkg::hex_value(char_i.character);
  assign id_digits = ext_q ? acfp_pkg::POS_W'(acfp_pkg::EXT_ID_DIGITS)
                           : acfp_pkg::POS_W'(acfp_pkg::STD_ID_DIGITS);
  assign id_limit  = ext_q ? acfp_pkg::EXT_ID_MAX : acfp_pkg::STD_ID_MAX;
  assign pos_inc   = pos_q + 1'b1;
  assign id_shift  = {id_q[acfp_pkg::ACC_ID_W-acfp_pkg::NIBBLE_W-1:0], digit};
  // Data digit index after the length digit; the high nibble of each byte
  // arrives first, so the nibble slot is the index with its low bit flipped.
  assign data_idx  = pos_q - id_digits - 1'b1;
  assign nib_idx   = {data_idx[acfp_pkg::POS_W-1:1], ~data_idx[0]};

  assign letter_ok = (char_i.character == acfp_pkg::CHAR_STD_DATA)
                  || (char_i.character == acfp_pkg::CHAR_EXT_DATA)
                  || (char_i.character == acfp_pkg::CHAR_STD_RTR)
                  || (char_i.character == acfp_pkg::CHAR_EXT_RTR);

  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    ext_d    = ext_q;
    rem_d    = rem_q;
    id_d     = id_q;
    len_d    = len_q;
    pay_d    = pay_q;
    emit     = 1'b0;
    status   = acfp_pkg::STATUS_OK;

    if (char_i.line_start) begin
      pos_d = '0;
      id_d  = '0;
      len_d = '0;
      pay_d = '0;
      if (letter_ok) begin
        ext_d    = (char_i.character == acfp_pkg::CHAR_EXT_DATA)
                || (char_i.character == acfp_pkg::CHAR_EXT_RTR);
        rem_d    = (char_i.character == acfp_pkg::CHAR_STD_RTR)
                || (char_i.character == acfp_pkg::CHAR_EXT_RTR);
        active_d = 1'b1;
      end else begin
        ext_d  = 1'b0;
        rem_d  = 1'b0;
        emit   = 1'b1;
        status = acfp_pkg::STATUS_BAD_CMD;
      end
    end else if (active_q) begin
      pos_d = pos_inc;
      if (pos_q < id_digits) begin
        id_d = id_shift;
        if (pos_inc == id_digits && id_shift > id_limit) begin
          emit   = 1'b1;
          status = acfp_pkg::STATUS_BAD_ID;
        end
      end else if (pos_q == id_digits) begin
        len_d = digit;
        if (digit > acfp_pkg::LEN_W'(MaxDataBytes)) begin
          emit   = 1'b1;
          status = acfp_pkg::STATUS_BAD_LEN;
        end else if (rem_q || digit == '0) begin
          emit = 1'b1;
        end
      end else begin
        for (int n = 0; n < Nibbles; n++) begin
          if (nib_idx == acfp_pkg::POS_W'(n)) begin
            pay_d[n*acfp_pkg::NIBBLE_W +: acfp_pkg::NIBBLE_W] =
              pay_q[n*acfp_pkg::NIBBLE_W +: acfp_pkg::NIBBLE_W] | digit;
          end
        end
        if ({1'b0, data_idx} + 1'b1 >= {1'b0, len_q, 1'b0}) begin
          emit = 1'b1;
        end
      end
    end

    if (emit) begin
      active_d = 1'b0;
    end
  end

  always_comb begin
    res_o.status     = status;
    res_o.extended   = ext_d;
    res_o.remote     = rem_d;
    res_o.identifier = '0;
    res_o.byte_count = '0;
    res_o.payload    = '0;
    if (status == acfp_pkg::STATUS_OK) begin
      res_o.identifier = id_d[acfp_pkg::ID_W-1:0];
      res_o.byte_count = len_d;
      res_o.payload    = acfp_pkg::PAYLOAD_W'(pay_d);
    end
  end

  assign res_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      ext_q    <= 1'b0;
      rem_q    <= 1'b0;
      id_q     <= '0;
      len_q    <= '0;
      pay_q    <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      ext_q    <= ext_d;
      rem_q    <= rem_d;
      id_q     <= id_d;
      len_q    <= len_d;
      pay_q    <= pay_d;
    end
  end

  a_err_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != acfp_pkg::STATUS_OK
      |-> res_o.identifier == '0 && res_o.byte_count == '0 && res_o.payload == '0)
    else $error("failed frame carries nonzero identifier, length or data");

  a_ok_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == acfp_pkg::STATUS_OK
      |-> res_o.byte_count <= acfp_pkg::LEN_W'(MaxDataBytes))
    else $error("good frame reports a length above the data limit");

  a_idle_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !active_q)
    else $error("parser still active after giving a frame");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pos_q <= acfp_pkg::POS_W'(PosMax))
    else $error("character position ran past the longest command");

  a_idle_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !char_i.line_start && !active_q |-> !res_valid_o)
    else $error("frame given for a character outside a command");

endmodule

FILE: src/acfp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one parsed frame until the sink takes it and tells the parser
// when it may step.
// ----------------------------------------------------------------------------
module acfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  acfp_pkg::frame_t  res_i,
  output logic              advance_o,
  output logic              valid_o,
  input  logic              ready_i,
  output acfp_pkg::frame_t  frame_o
);

  logic             valid_q, valid_d;
  acfp_pkg::frame_t frame_q;

  // The parser may step whenever this register is empty or being emptied.
  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      frame_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

FILE: src/ascii_can_frame_parser.sv
// ----------------------------------------------------------------------------
// ASCII CAN frame parser
// Parses serial-line CAN frame commands, one character per transaction.
//
//   Channel   Direction  Carries
//   char_i    in         character, line_start
//   frame_o   out        status, extended, remote, identifier, byte_count,
//                        payload
//
// One character is taken per cycle while no stalled frame holds the flow.
// frame_o.valid rises once the character that completes or fails the command
// has left the input register and its frame is held in the result register.
// The parser step between the two registers is combinational; only the sink stalls it.
// A stalled frame holds in the result register; one more character waits
// in the input register, then char_i.ready drops.
// Reset clears the valid flags and the parser to idle.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser #(
  parameter int unsigned MaxDataBytes = acfp_pkg::MAX_DATA_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  acfp_char_if.sink     char_i,
  acfp_frame_if.source  frame_o
);

  logic             in_valid;
  acfp_pkg::char_t  in_char;
  logic             advance;
  logic             step;
  logic             res_valid;
  acfp_pkg::frame_t res;
  acfp_pkg::frame_t frame;

  acfp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (char_i.valid),
    .ready_o      (char_i.ready),
    .character_i  (char_i.character),
    .line_start_i (char_i.line_start),
    .advance_i    (advance),
    .valid_o      (in_valid),
    .char_o       (in_char)
  );

  assign step = in_valid && advance;

  acfp_core #(
    .MaxDataBytes (MaxDataBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (in_char),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  acfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .valid_o     (frame_o.valid),
    .ready_i     (frame_o.ready),
    .frame_o     (frame)
  );

  assign frame_o.status     = frame.status;
  assign frame_o.extended   = frame.extended;
  assign frame_o.remote     = frame.remote;
  assign frame_o.identifier = frame.identifier;
  assign frame_o.byte_count = frame.byte_count;
  assign frame_o.payload    = frame.payload;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII CAN frame parser testbench
// Sends serial-line CAN command characters through the character channel,
// tracks the parser state alongside the block to predict every frame, and
// checks each frame transaction field by field in order. Directed tests cover
// the command letters and the error cases; random phases with varied idling
// on both channels cover the rest.
// ----------------------------------------------------------------------------
module tb_top;
  import acfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PHASE_CHARS  = 475;
  localparam int unsigned MAX_REPORTS  = 40;

  logic clk;
  logic rst_n;

  acfp_char_if  char_if ();
  acfp_frame_if frame_if ();

  ascii_can_frame_parser dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .char_i  (char_if),
    .frame_o (frame_if)
  );

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned accepted_chars = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  frame_t pending_frames[$];

  // Parser state tracked alongside the block.
  logic                 parser_busy;
  logic                 parse_ext;
  logic                 parse_rtr;
  logic [POS_W-1:0]     parse_pos;
  logic [ACC_ID_W-1:0]  parse_id;
  logic [LEN_W-1:0]     parse_len;
  logic [PAYLOAD_W-1:0] parse_data;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ascii_can_frame_parser verification failed");
    $finish;
  end

  function automatic logic [NIBBLE_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [NIBBLE_W-1:0] nib;
    nib = '0;
    // Digits carry their value in the low nibble; letters A-F and a-f sit
    // nine below theirs.
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      nib = c[3:0];
    end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F], [CHAR_LOWER_A:CHAR_LOWER_F]}) begin
      nib = c[3:0] + 4'd9;
    end
    return nib;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIBBLE_W-1:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + nib;
    end else begin
      c = ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + nib - 4'd10;
    end
    return c;
  endfunction

  task automatic push_frame(input status_e st);
    frame_t f;
    logic   ok;
    ok           = (st == STATUS_OK);
    f.status     = st;
    f.extended   = parse_ext;
    f.remote     = parse_rtr;
    f.identifier = ok ? parse_id[ID_W-1:0] : '0;
    f.byte_count = ok ? parse_len : '0;
    f.payload    = ok ? parse_data : '0;
    pending_frames.push_back(f);
    parser_busy = 1'b0;
  endtask

  task automatic reset_parser_state();
    parser_busy = 1'b0;
    parse_ext   = 1'b0;
    parse_rtr   = 1'b0;
    parse_pos   = '0;
    parse_id    = '0;
    parse_len   = '0;
    parse_data  = '0;
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic s);
    logic [NIBBLE_W-1:0] nib;
    int unsigned         digits;
    int unsigned         k;
    int unsigned         sh;
    if (s) begin
      parse_pos  = '0;
      parse_id   = '0;
      parse_len  = '0;
      parse_data = '0;
      if (!(c inside {CHAR_STD_DATA, CHAR_EXT_DATA, CHAR_STD_RTR, CHAR_EXT_RTR})) begin
        parse_ext = 1'b0;
        parse_rtr = 1'b0;
        push_frame(STATUS_BAD_CMD);
      end else begin
        parse_ext   = (c == CHAR_EXT_DATA) || (c == CHAR_EXT_RTR);
        parse_rtr   = (c == CHAR_STD_RTR) || (c == CHAR_EXT_RTR);
        parser_busy = 1'b1;
      end
    end else if (parser_busy) begin
      nib    = nibble_of(c);
      digits = parse_ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
      if (parse_pos < digits) begin
        parse_id  = {parse_id[ACC_ID_W-NIBBLE_W-1:0], nib};
        parse_pos = parse_pos + 1'b1;
        if (parse_pos == digits && parse_id > (parse_ext ? EXT_ID_MAX : STD_ID_MAX)) begin
          push_frame(STATUS_BAD_ID);
        end
      end else if (parse_pos == digits) begin
        parse_len = nib;
        parse_pos = parse_pos + 1'b1;
        if (parse_len > MAX_DATA_BYTES) begin
          push_frame(STATUS_BAD_LEN);
        end else if (parse_rtr || parse_len == '0) begin
          push_frame(STATUS_OK);
        end
      end else begin
        // Data digits come high nibble first, first byte lowest.
        k          = parse_pos - digits - 1;
        sh         = ((k >> 1) & 7) * 8 + (k[0] ? 0 : 4);
        parse_data = parse_data | (PAYLOAD_W'(nib) << sh);
        parse_pos  = parse_pos + 1'b1;
        if (k + 1 >= 2 * parse_len) begin
          push_frame(STATUS_OK);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  // Frame sink: random stalls, and a check of every frame transaction.
  initial begin
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      frame_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && frame_if.valid && frame_if.ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame", 64'(frame_if.identifier), '0);
      end else begin
        want = pending_frames.pop_front();
        if (frame_if.status != want.status)
          report_mismatch("status", 64'(frame_if.status), 64'(want.status));
        if (frame_if.extended != want.extended)
          report_mismatch("extended", 64'(frame_if.extended), 64'(want.extended));
        if (frame_if.remote != want.remote)
          report_mismatch("remote", 64'(frame_if.remote), 64'(want.remote));
        if (frame_if.identifier != want.identifier)
          report_mismatch("identifier", 64'(frame_if.identifier), 64'(want.identifier));
        if (frame_if.byte_count != want.byte_count)
          report_mismatch("byte_count", 64'(frame_if.byte_count), 64'(want.byte_count));
        if (frame_if.payload != want.payload)
          report_mismatch("payload", frame_if.payload, want.payload);
      end
    end
  end

  // Returns at the rising edge at which the character transaction completes.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic s);
    logic counts;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      char_if.valid <= 1'b0;
      @(negedge clk);
    end
    char_if.valid      <= 1'b1;
    char_if.character  <= c;
    char_if.line_start <= s;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    counts = s || parser_busy;
    parse_char(c, s);
    if (counts) accepted_chars++;
  endtask

  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], i == 0);
    end
  endtask

  task automatic wait_for_frames();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_command_letters();
    send_char(8'h00, 1'b1);   // not a command letter
    send_char(8'h55, 1'b0);   // ignored while idle
    send_string("t1");        // cut short by the next command
  endtask

  task automatic test_standard_frames();
    send_string("t7fF0");     // largest standard identifier, zero length
    send_string("t800");      // standard identifier out of range
  endtask

  task automatic test_extended_remote();
    send_string("R1FFFFFFF8");
  endtask

  task automatic test_length_limit();
    send_string("r0z0F");     // non-hex digit reads as zero, length too large
  endtask

  task automatic send_random_command();
    logic [CHAR_W-1:0]    text[$];
    logic [CHAR_W-1:0]    letter;
    logic [ACC_ID_W-1:0]  ident;
    logic [PAYLOAD_W-1:0] data;
    logic                 ext;
    logic                 rtr;
    int unsigned          kind;
    int unsigned          len;
    int unsigned          digits;
    int unsigned          cut;
    kind = $urandom_range(99);
    if (kind >= 97) begin
      // Noise: arbitrary characters with line_start set now and then.
      repeat ($urandom_range(1, 6)) begin
        send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
      end
      return;
    end
    ext    = $urandom_range(1);
    rtr    = ($urandom_range(3) == 0);
    digits = ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
    case ({ext, rtr})
      2'b00: letter = CHAR_STD_DATA;
      2'b01: letter = CHAR_STD_RTR;
      2'b10: letter = CHAR_EXT_DATA;
      default: letter = CHAR_EXT_RTR;
    endcase
    if ($urandom_range(24) == 0) letter = CHAR_W'($urandom_range(255));
    if (kind >= 80 && kind < 88) begin
      ident = ext ? $urandom_range(32'hffff_ffff, 32'h2000_0000) : $urandom_range(12'hfff, 12'h800);
    end else begin
      case ($urandom_range(9))
        0: ident = ext ? EXT_ID_MAX : STD_ID_MAX;
        1: ident = '0;
        default: ident = $urandom & (ext ? EXT_ID_MAX : STD_ID_MAX);
      endcase
    end
    len  = (kind >= 88 && kind < 94) ? $urandom_range(15, 9) : $urandom_range(MAX_DATA_BYTES);
    data = {$urandom, $urandom};
    text.push_back(letter);
    for (int i = digits - 1; i >= 0; i--) text.push_back(hex_char(ident[4*i +: 4]));
    text.push_back(hex_char(len[3:0]));
    if (!rtr && len <= MAX_DATA_BYTES) begin
      for (int b = 0; b < len; b++) begin
        text.push_back(hex_char(data[8*b+4 +: 4]));
        text.push_back(hex_char(data[8*b +: 4]));
      end
    end
    if ($urandom_range(19) == 0) begin
      text[$urandom_range(text.size() - 1, 1)] = CHAR_W'($urandom_range(255));
    end
    if (kind >= 94) begin
      cut = $urandom_range(text.size() - 1, 1);
      while (text.size() > cut) void'(text.pop_back());
    end else if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(CHAR_W'($urandom_range(255)));
    end
    foreach (text[i]) send_char(text[i], i == 0);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned goal;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    goal           = accepted_chars + PHASE_CHARS;
    while (accepted_chars < goal) send_random_command();
    wait_for_frames();
  endtask

  initial begin
    char_if.valid      = 1'b0;
    char_if.character  = '0;
    char_if.line_start = 1'b0;
    rst_n              = 1'b0;
    reset_parser_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_command_letters();
    test_standard_frames();
    test_extended_remote();
    test_length_limit();
    // The sender holds off here until every frame so far has come out.
    wait_for_frames();

    test_random(0, 0);
    test_random(68, 0);
    test_random(0, 68);
    test_random(22, 22);

    wait_for_frames();
    if (mismatch_count == 0) begin
      $display("ascii_can_frame_parser verification clean");
    end else begin
      $display("ascii_can_frame_parser verification failed");
    end
    $finish;
  end

endmodule
